>>> rtl/core/gnd_pkg.sv
// Package for the 2D gradient noise elevation block.
// Holds the fixed-point constants, the register index codes and the item word type.
// No dependencies.
`default_nettype none

package gnd_pkg;

  // Fraction bits of offsets, gradients and fade weights.
  localparam int FRAC_BITS = 14;
  // Largest usable map side; map_size is capped here.
  localparam int MAX_MAP_SIDE = 4096;
  // Width of the size and step registers.
  localparam int CFG_W = 13;
  // Bits of an in-range coordinate.
  localparam int XW = $clog2(MAX_MAP_SIDE);
  // Quotient bits of (coordinate << FRAC_BITS) / grid_step.
  localparam int QW = XW + FRAC_BITS;
  // Width of a dot product or a blended value after rounding down.
  localparam int DOT_W = 18;
  // Right shift that takes the scaled value from 26 to 16 fraction bits.
  localparam int OUT_SHIFT = 10;

  localparam logic [CFG_W-1:0] MAX_SIDE = CFG_W'(MAX_MAP_SIDE);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAP_SIZE    = 2'd0,
    REG_GRID_STEP   = 2'd1,
    REG_NORM_OFFSET = 2'd2,
    REG_NORM_GAIN   = 2'd3
  } cfg_reg_t;

  // One classified input word as it travels from the front to the back.
  typedef struct packed {
    logic               is_query;
    logic               bad;
    logic [XW-1:0]      x;
    logic [XW-1:0]      y;
    logic [11:0]        node_index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/gnd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gnd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/gnd_front.sv
// Front end: accepts input words and classifies them for the back end.
// Depends on gnd_pkg.
`default_nettype none

module gnd_front (
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      req_type,
  input  wire logic [15:0]               pos_x,
  input  wire logic [15:0]               pos_y,
  input  wire logic [11:0]               node_index,
  input  wire logic signed [15:0]        grad_x,
  input  wire logic signed [15:0]        grad_y,
  input  wire logic [gnd_pkg::CFG_W-1:0] size_eff,
  input  wire logic [gnd_pkg::CFG_W-1:0] grid_step,
  input  wire logic                      q_full,
  output logic                           push,
  output gnd_pkg::item_t                 push_item
);

  import gnd_pkg::*;

  // A word is taken whenever the queue has room.
  assign busy = q_full;
  assign push = start && !q_full;

  // Flag queries that fall off the map or use a zero step.
  always_comb begin
    push_item.is_query   = req_type;
    push_item.bad        = (grid_step == '0) ||
                           (pos_x >= 16'(size_eff)) || (pos_y >= 16'(size_eff));
    push_item.x          = XW'(pos_x);
    push_item.y          = XW'(pos_y);
    push_item.node_index = node_index;
    push_item.grad_x     = grad_x;
    push_item.grad_y     = grad_y;
  end

endmodule

`default_nettype wire

>>> rtl/core/gnd_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on gnd_pkg.
`default_nettype none

module gnd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire gnd_pkg::item_t  push_item,
  output logic                 full,
  output logic                 valid,
  output gnd_pkg::item_t       item
);

  import gnd_pkg::*;

  localparam int DEPTH = 2;

  item_t      entries [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  // The back end never stalls, so the head word leaves whenever present.
  assign valid = (count != 2'd0);
  assign full  = (count == 2'(DEPTH));
  assign pop   = valid;
  assign item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gnd_divider.sv
// Pipelined restoring divider: one quotient bit per stage for x and y,
// and size over step in the first stages. Depends on gnd_pkg.
`default_nettype none

module gnd_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire gnd_pkg::item_t            in_item,
  input  wire logic [gnd_pkg::CFG_W-1:0] step,
  input  wire logic [gnd_pkg::CFG_W-1:0] size_eff,
  output logic                           out_valid,
  output gnd_pkg::item_t                 out_item,
  output logic [gnd_pkg::QW-1:0]         qx,
  output logic [gnd_pkg::QW-1:0]         qy,
  output logic [gnd_pkg::CFG_W-1:0]      qs
);

  import gnd_pkg::*;

  localparam int RW = CFG_W;
  localparam int SW = CFG_W;

  logic [QW-1:0]   s_v;
  item_t           s_it [QW];
  logic [RW-1:0]   s_rx [QW];
  logic [RW-1:0]   s_ry [QW];
  logic [RW-1:0]   s_rs [QW];
  logic [QW-1:0]   s_qx [QW];
  logic [QW-1:0]   s_qy [QW];
  logic [SW-1:0]   s_qs [QW];

  logic [QW-1:0]   n_v;
  item_t           n_it [QW];
  logic [RW-1:0]   n_rx [QW];
  logic [RW-1:0]   n_ry [QW];
  logic [RW-1:0]   n_rs [QW];
  logic [QW-1:0]   n_qx [QW];
  logic [QW-1:0]   n_qy [QW];
  logic [SW-1:0]   n_qs [QW];

  // One shift, compare and subtract per stage for each dividend.
  always_comb begin
    item_t         it_i;
    logic [RW-1:0] rx_i;
    logic [RW-1:0] ry_i;
    logic [RW-1:0] rs_i;
    logic [QW-1:0] qx_i;
    logic [QW-1:0] qy_i;
    logic [SW-1:0] qs_i;
    logic [QW-1:0] dvx;
    logic [QW-1:0] dvy;
    logic [RW:0]   shx;
    logic [RW:0]   shy;
    logic [RW:0]   shs;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        n_v[i] = in_valid;
        it_i   = in_item;
        rx_i   = '0;
        ry_i   = '0;
        rs_i   = '0;
        qx_i   = '0;
        qy_i   = '0;
        qs_i   = '0;
      end else begin
        n_v[i] = s_v[i-1];
        it_i   = s_it[i-1];
        rx_i   = s_rx[i-1];
        ry_i   = s_ry[i-1];
        rs_i   = s_rs[i-1];
        qx_i   = s_qx[i-1];
        qy_i   = s_qy[i-1];
        qs_i   = s_qs[i-1];
      end
      n_it[i] = it_i;
      dvx = {it_i.x, {FRAC_BITS{1'b0}}};
      dvy = {it_i.y, {FRAC_BITS{1'b0}}};
      shx = {rx_i, dvx[QW-1-i]};
      shy = {ry_i, dvy[QW-1-i]};
      if (shx >= {1'b0, step}) begin
        n_rx[i] = RW'(shx - {1'b0, step});
        n_qx[i] = {qx_i[QW-2:0], 1'b1};
      end else begin
        n_rx[i] = RW'(shx);
        n_qx[i] = {qx_i[QW-2:0], 1'b0};
      end
      if (shy >= {1'b0, step}) begin
        n_ry[i] = RW'(shy - {1'b0, step});
        n_qy[i] = {qy_i[QW-2:0], 1'b1};
      end else begin
        n_ry[i] = RW'(shy);
        n_qy[i] = {qy_i[QW-2:0], 1'b0};
      end
      // Size over step is finished after the first SW stages and then held.
      if (i < SW) begin
        shs = {rs_i, size_eff[SW-1-i]};
        if (shs >= {1'b0, step}) begin
          n_rs[i] = RW'(shs - {1'b0, step});
          n_qs[i] = {qs_i[SW-2:0], 1'b1};
        end else begin
          n_rs[i] = RW'(shs);
          n_qs[i] = {qs_i[SW-2:0], 1'b0};
        end
      end else begin
        shs     = '0;
        n_rs[i] = rs_i;
        n_qs[i] = qs_i;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= '0;
    end else begin
      s_v <= n_v;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    s_it <= n_it;
    s_rx <= n_rx;
    s_ry <= n_ry;
    s_rs <= n_rs;
    s_qx <= n_qx;
    s_qy <= n_qy;
    s_qs <= n_qs;
  end

  assign out_valid = s_v[QW-1];
  assign out_item  = s_it[QW-1];
  assign qx        = s_qx[QW-1];
  assign qy        = s_qy[QW-1];
  assign qs        = s_qs[QW-1];

endmodule

`default_nettype wire

>>> rtl/core/gnd_back.sv
// Back end: cell lookup, gradient table, dot products, fade, blends and scaling.
// Depends on gnd_pkg, gnd_divider and gnd_ram.
`default_nettype none

module gnd_back #(
  parameter int GRID_NODES = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire gnd_pkg::item_t            in_item,
  input  wire logic [gnd_pkg::CFG_W-1:0] size_eff,
  input  wire logic [gnd_pkg::CFG_W-1:0] grid_step,
  input  wire logic [15:0]               norm_offset,
  input  wire logic [15:0]               norm_gain,
  output logic                           done,
  output logic [15:0]                    elevation,
  output logic                           in_range
);

  import gnd_pkg::*;

  localparam int IW   = $clog2(GRID_NODES);
  localparam int SW   = CFG_W;
  localparam int AL_W = XW + SW + 2;
  localparam int F    = FRAC_BITS;
  localparam int VW   = DOT_W + 1 + 17;

  // Gradient vector dotted with a corner offset, rounded down.
  function automatic logic signed [DOT_W-1:0] corner_dot(
    input logic [31:0]         g,
    input logic signed [F+1:0] ox,
    input logic signed [F+1:0] oy
  );
    logic signed [15:0]   gx;
    logic signed [15:0]   gy;
    logic signed [F+17:0] px;
    logic signed [F+17:0] py;
    logic signed [F+18:0] acc;
    gx  = signed'(g[15:0]);
    gy  = signed'(g[31:16]);
    px  = gx * ox;
    py  = gy * oy;
    acc = (F+19)'(px) + (F+19)'(py);
    return acc[F+DOT_W-1:F];
  endfunction

  // Linear blend of a and b by weight w, rounded down.
  function automatic logic signed [DOT_W-1:0] blend(
    input logic signed [DOT_W-1:0] a,
    input logic signed [DOT_W-1:0] b,
    input logic [F:0]              w
  );
    logic signed [F+1:0]         ws;
    logic signed [F+1:0]         omw;
    logic signed [DOT_W+F+1:0]   pa;
    logic signed [DOT_W+F+1:0]   pb;
    logic signed [DOT_W+F+2:0]   acc;
    ws  = signed'({1'b0, w});
    omw = signed'({1'b0, ONE}) - ws;
    pa  = a * omw;
    pb  = b * ws;
    acc = (DOT_W+F+3)'(pa) + (DOT_W+F+3)'(pb);
    return acc[F+DOT_W-1:F];
  endfunction

  // Smoothstep 3t^2 - 2t^3 from its square and cube, capped at one.
  function automatic logic [F:0] fade_of(input logic [F-1:0] t2, input logic [F-1:0] t3);
    logic [F+2:0] fsum;
    fsum = ((F+3)'(t2) << 1) + (F+3)'(t2) - ((F+3)'(t3) << 1);
    return (fsum > (F+3)'(ONE)) ? ONE : (F+1)'(fsum);
  endfunction

  // Divider front of the back end.
  logic              d_v;
  item_t             d_it;
  logic [QW-1:0]     d_qx;
  logic [QW-1:0]     d_qy;
  logic [SW-1:0]     d_qs;

  gnd_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .step      (grid_step),
    .size_eff  (size_eff),
    .out_valid (d_v),
    .out_item  (d_it),
    .qx        (d_qx),
    .qy        (d_qy),
    .qs        (d_qs)
  );

  // Stage 1: cell base index, first fade product.
  logic              c1_v;
  item_t             c1_it;
  logic [F-1:0]      c1_fx;
  logic [F-1:0]      c1_fy;
  logic [AL_W-1:0]   c1_al;
  logic [SW:0]       c1_nps;
  logic [F-1:0]      c1_t2x;
  logic [F-1:0]      c1_t2y;

  logic [SW:0]       nps_d;
  logic [XW+SW:0]    row_base;
  logic [2*F-1:0]    sqx;
  logic [2*F-1:0]    sqy;

  always_comb begin
    nps_d    = {1'b0, d_qs} + (SW+1)'(1);
    row_base = d_qy[QW-1:F] * nps_d;
    sqx      = d_qx[F-1:0] * d_qx[F-1:0];
    sqy      = d_qy[F-1:0] * d_qy[F-1:0];
  end

  always_ff @(posedge clk) begin
    c1_it  <= d_it;
    c1_fx  <= d_qx[F-1:0];
    c1_fy  <= d_qy[F-1:0];
    c1_al  <= AL_W'(row_base) + AL_W'(d_qx[QW-1:F]);
    c1_nps <= nps_d;
    c1_t2x <= sqx[2*F-1:F];
    c1_t2y <= sqy[2*F-1:F];
  end

  // Stage 2: four corner indexes, table bound check, cube term.
  logic              c2_v;
  item_t             c2_it;
  logic [IW-1:0]     c2_al;
  logic [IW-1:0]     c2_ar;
  logic [IW-1:0]     c2_bl;
  logic [IW-1:0]     c2_br;
  logic [F-1:0]      c2_fx;
  logic [F-1:0]      c2_fy;
  logic [F-1:0]      c2_t2x;
  logic [F-1:0]      c2_t2y;
  logic [F-1:0]      c2_t3x;
  logic [F-1:0]      c2_t3y;

  logic [AL_W-1:0]   idx_bl;
  logic [AL_W-1:0]   idx_br;
  logic [2*F-1:0]    cbx;
  logic [2*F-1:0]    cby;
  item_t             c1_chk;

  // The word also turns bad when its lower-right node lies past the table.
  always_comb begin
    idx_bl     = c1_al + AL_W'(c1_nps);
    idx_br     = idx_bl + AL_W'(1);
    cbx        = c1_t2x * c1_fx;
    cby        = c1_t2y * c1_fy;
    c1_chk     = c1_it;
    c1_chk.bad = c1_it.bad || (32'(idx_br) >= 32'(GRID_NODES));
  end

  always_ff @(posedge clk) begin
    c2_it     <= c1_chk;
    c2_al     <= IW'(c1_al);
    c2_ar     <= IW'(c1_al + AL_W'(1));
    c2_bl     <= IW'(idx_bl);
    c2_br     <= IW'(idx_br);
    c2_fx     <= c1_fx;
    c2_fy     <= c1_fy;
    c2_t2x    <= c1_t2x;
    c2_t2y    <= c1_t2y;
    c2_t3x    <= cbx[2*F-1:F];
    c2_t3y    <= cby[2*F-1:F];
  end

  // Gradient table: four copies so that all corners are read together.
  // Writes take effect here, in order with the reads of queries.
  logic              tbl_we;
  logic [31:0]       tbl_wdata;
  logic [IW-1:0]     tbl_raddr [4];
  logic [31:0]       tbl_rdata [4];

  assign tbl_we       = c2_v && !c2_it.is_query &&
                        (32'(c2_it.node_index) < 32'(GRID_NODES));
  assign tbl_wdata    = {c2_it.grad_y, c2_it.grad_x};
  assign tbl_raddr[0] = c2_al;
  assign tbl_raddr[1] = c2_ar;
  assign tbl_raddr[2] = c2_bl;
  assign tbl_raddr[3] = c2_br;

  for (genvar k = 0; k < 4; k++) begin : g_tbl
    gnd_ram #(
      .WIDTH (32),
      .DEPTH (GRID_NODES)
    ) u_ram (
      .clk   (clk),
      .we    (tbl_we),
      .waddr (IW'(c2_it.node_index)),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr[k]),
      .rdata (tbl_rdata[k])
    );
  end

  // Stage 3: fade weights; gradients arrive from the table.
  logic              c3_v;
  logic              c3_q;
  logic              c3_bad;
  logic [F-1:0]      c3_fx;
  logic [F-1:0]      c3_fy;
  logic [F:0]        c3_wx;
  logic [F:0]        c3_wy;

  always_ff @(posedge clk) begin
    c3_q   <= c2_it.is_query;
    c3_bad <= c2_it.bad;
    c3_fx  <= c2_fx;
    c3_fy  <= c2_fy;
    c3_wx  <= fade_of(c2_t2x, c2_t3x);
    c3_wy  <= fade_of(c2_t2y, c2_t3y);
  end

  // Stage 4: corner dot products.
  logic                     c4_v;
  logic                     c4_q;
  logic                     c4_bad;
  logic signed [DOT_W-1:0]  c4_u;
  logic signed [DOT_W-1:0]  c4_r;
  logic signed [DOT_W-1:0]  c4_s;
  logic signed [DOT_W-1:0]  c4_t;
  logic [F:0]               c4_wx;
  logic [F:0]               c4_wy;

  logic signed [F+1:0] ox_l;
  logic signed [F+1:0] ox_r;
  logic signed [F+1:0] oy_t;
  logic signed [F+1:0] oy_b;

  always_comb begin
    ox_l = signed'({2'b00, c3_fx});
    oy_t = signed'({2'b00, c3_fy});
    ox_r = ox_l - signed'({1'b0, ONE});
    oy_b = oy_t - signed'({1'b0, ONE});
  end

  always_ff @(posedge clk) begin
    c4_q   <= c3_q;
    c4_bad <= c3_bad;
    c4_u   <= corner_dot(tbl_rdata[0], ox_l, oy_t);
    c4_r   <= corner_dot(tbl_rdata[1], ox_r, oy_t);
    c4_s   <= corner_dot(tbl_rdata[2], ox_l, oy_b);
    c4_t   <= corner_dot(tbl_rdata[3], ox_r, oy_b);
    c4_wx  <= c3_wx;
    c4_wy  <= c3_wy;
  end

  // Stage 5: blend along x for the upper and lower edges.
  logic                     c5_v;
  logic                     c5_q;
  logic                     c5_bad;
  logic signed [DOT_W-1:0]  c5_top;
  logic signed [DOT_W-1:0]  c5_bottom;
  logic [F:0]               c5_wy;

  always_ff @(posedge clk) begin
    c5_q      <= c4_q;
    c5_bad    <= c4_bad;
    c5_top    <= blend(c4_u, c4_r, c4_wx);
    c5_bottom <= blend(c4_s, c4_t, c4_wx);
    c5_wy     <= c4_wy;
  end

  // Stage 6: blend along y.
  logic                     c6_v;
  logic                     c6_q;
  logic                     c6_bad;
  logic signed [DOT_W-1:0]  c6_sum;

  always_ff @(posedge clk) begin
    c6_q   <= c5_q;
    c6_bad <= c5_bad;
    c6_sum <= blend(c5_top, c5_bottom, c5_wy);
  end

  // Stage 7: offset and gain.
  logic                     c7_v;
  logic                     c7_q;
  logic                     c7_bad;
  logic signed [VW-1:0]     c7_val;

  logic signed [DOT_W:0]    biased;
  logic signed [16:0]       gain_s;

  always_comb begin
    biased = (DOT_W+1)'(c6_sum) + signed'({3'b000, norm_offset});
    gain_s = signed'({1'b0, norm_gain});
  end

  always_ff @(posedge clk) begin
    c7_q   <= c6_q;
    c7_bad <= c6_bad;
    c7_val <= biased * gain_s;
  end

  // Output register: clamp to Q0.16, or zero when off the map or table.
  always_ff @(posedge clk) begin
    if (c7_bad) begin
      elevation <= '0;
      in_range  <= 1'b0;
    end else if (c7_val < 0) begin
      elevation <= '0;
      in_range  <= 1'b1;
    end else if (|c7_val[VW-1:OUT_SHIFT+16]) begin
      elevation <= 16'hFFFF;
      in_range  <= 1'b1;
    end else begin
      elevation <= c7_val[OUT_SHIFT+15:OUT_SHIFT];
      in_range  <= 1'b1;
    end
  end

  // Valid bits of all stages; only queries raise the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      c3_v <= 1'b0;
      c4_v <= 1'b0;
      c5_v <= 1'b0;
      c6_v <= 1'b0;
      c7_v <= 1'b0;
      done <= 1'b0;
    end else begin
      c1_v <= d_v;
      c2_v <= c1_v;
      c3_v <= c2_v;
      c4_v <= c3_v && c3_q;
      c5_v <= c4_v && c4_q;
      c6_v <= c5_v && c5_q;
      c7_v <= c6_v && c6_q;
      done <= c7_v && c7_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/gradient_noise_2d_elevation.sv
// A query word passes through the queue, the divider pipeline and the back-end stages
// before its result strobe rises; a table write word gives no result.
// Throughput: one word per cycle, set by the bit-per-stage divider pipeline.
// busy stays low in steady flow; the receiver cannot stall and takes each result.
// Reset: synchronous, clears control state and loads the register defaults;
// the gradient table holds no value until written.
`default_nettype none

module gradient_noise_2d_elevation #(
  parameter int GRID_NODES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  input  wire logic [11:0]        node_index,
  input  wire logic signed [15:0] grad_x,
  input  wire logic signed [15:0] grad_y,
  output logic                    done,
  output logic [15:0]             elevation,
  output logic                    in_range,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  import gnd_pkg::*;

  logic [CFG_W-1:0] map_size;
  logic [CFG_W-1:0] grid_step;
  logic [15:0]      norm_offset;
  logic [15:0]      norm_gain;
  logic [CFG_W-1:0] size_eff;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_size    <= CFG_W'(1024);
      grid_step   <= CFG_W'(64);
      norm_offset <= 16'd11585;
      norm_gain   <= 16'd2896;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_SIZE:    map_size    <= cfg_data[CFG_W-1:0];
        REG_GRID_STEP:   grid_step   <= cfg_data[CFG_W-1:0];
        REG_NORM_OFFSET: norm_offset <= cfg_data;
        REG_NORM_GAIN:   norm_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map side capped at the largest supported side.
  assign size_eff = (map_size > MAX_SIDE) ? MAX_SIDE : map_size;

  logic  q_full;
  logic  push;
  item_t push_item;
  logic  q_valid;
  item_t q_item;

  gnd_front u_front (
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .node_index (node_index),
    .grad_x     (grad_x),
    .grad_y     (grad_y),
    .size_eff   (size_eff),
    .grid_step  (grid_step),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  gnd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .valid     (q_valid),
    .item      (q_item)
  );

  gnd_back #(
    .GRID_NODES (GRID_NODES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .size_eff    (size_eff),
    .grid_step   (grid_step),
    .norm_offset (norm_offset),
    .norm_gain   (norm_gain),
    .done        (done),
    .elevation   (elevation),
    .in_range    (in_range)
  );

endmodule

`default_nettype wire

>>> verif/gnd_checker.sv
// Checker for the 2D gradient noise elevation block: watches the item, result and
// register channels, predicts each elevation and compares it with the block's result.
// Depends on gnd_pkg for the fixed-point constants and the register index codes.
`timescale 1ns / 100ps

module gnd_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               req_type,
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  input  wire logic [11:0]        node_index,
  input  wire logic signed [15:0] grad_x,
  input  wire logic signed [15:0] grad_y,
  input  wire logic               done,
  input  wire logic [15:0]        elevation,
  input  wire logic               in_range,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  output int                      errors,
  output int                      pending
);
  import gnd_pkg::*;

  localparam int NODES = 4096;
  localparam longint UNIT = 64'sd1 << FRAC_BITS;

  typedef struct {
    logic [15:0] elev;
    logic        on_map;
  } elev_t;

  logic [12:0] map_size_q;
  logic [12:0] grid_step_q;
  logic [15:0] norm_offset_q;
  logic [15:0] norm_gain_q;
  logic [31:0] grad_table [NODES];
  elev_t       elev_expected [$];

  // Dot product of one stored gradient with an offset, rounded down to Q.14.
  function automatic longint node_dot(int idx, longint ox, longint oy);
    longint gx;
    longint gy;
    gx = longint'($signed(grad_table[idx][15:0]));
    gy = longint'($signed(grad_table[idx][31:16]));
    return (gx * ox + gy * oy) >>> FRAC_BITS;
  endfunction

  // Smoothstep weight 3t^2 - 2t^3, held within 0..one.
  function automatic longint fade_weight(longint t);
    longint t2;
    longint t3;
    longint f;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    f = 3 * t2 - 2 * t3;
    if (f < 0) f = 0;
    if (f > UNIT) f = UNIT;
    return f;
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return (a * (UNIT - w) + b * w) >>> FRAC_BITS;
  endfunction

  // Expected result of one elevation query under the current registers.
  function automatic elev_t predict_elevation(logic [15:0] px, logic [15:0] py);
    elev_t  r;
    longint side;
    longint stp;
    longint nps;
    longint cx;
    longint cy;
    longint a_l;
    longint b_l;
    longint fx;
    longint fy;
    longint wx;
    longint wy;
    longint top;
    longint bot;
    longint total;
    longint val;
    r.elev = '0;
    r.on_map = 1'b0;
    side = (map_size_q > MAX_MAP_SIDE) ? MAX_MAP_SIDE : map_size_q;
    stp = grid_step_q;
    if (stp == 0 || px >= side || py >= side) return r;
    nps = 1 + side / stp;
    cx = px / stp;
    cy = py / stp;
    a_l = cy * nps + cx;
    b_l = (cy + 1) * nps + cx;
    if (b_l + 1 >= NODES) return r;
    fx = ((longint'(px) - cx * stp) << FRAC_BITS) / stp;
    fy = ((longint'(py) - cy * stp) << FRAC_BITS) / stp;
    wx = fade_weight(fx);
    wy = fade_weight(fy);
    bot = blend(node_dot(b_l, fx, fy - UNIT), node_dot(b_l + 1, fx - UNIT, fy - UNIT), wx);
    top = blend(node_dot(a_l, fx, fy), node_dot(a_l + 1, fx - UNIT, fy), wx);
    total = blend(top, bot, wy);
    val = (total + longint'(norm_offset_q)) * longint'(norm_gain_q);
    if (val < 0) val = 0;
    else begin
      val = val >>> 10;
      if (val > 65535) val = 65535;
    end
    r.elev = val[15:0];
    r.on_map = 1'b1;
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  // Register writes, table writes, query predictions and result checks.
  always @(posedge clk) begin
    elev_t got;
    elev_t want;
    if (rst) begin
      map_size_q <= 13'd1024;
      grid_step_q <= 13'd64;
      norm_offset_q <= 16'd11585;
      norm_gain_q <= 16'd2896;
      elev_expected.delete();
    end else begin
      // The oldest expectation is checked before this edge's word is queued.
      if (done) begin
        got.elev = elevation;
        got.on_map = in_range;
        if (elev_expected.size() == 0) begin
          $error("unexpected result word: elevation %0d in_range %0d", elevation, in_range);
          errors++;
        end else begin
          want = elev_expected.pop_front();
          if (got.elev !== want.elev) begin
            $error("elevation: expected %0d, actual %0d", want.elev, got.elev);
            errors++;
          end
          if (got.on_map !== want.on_map) begin
            $error("in_range: expected %0d, actual %0d", want.on_map, got.on_map);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        if (req_type) elev_expected.push_back(predict_elevation(pos_x, pos_y));
        else grad_table[node_index] <= {grad_y, grad_x};
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_SIZE:    map_size_q <= cfg_data[12:0];
          REG_GRID_STEP:   grid_step_q <= cfg_data[12:0];
          REG_NORM_OFFSET: norm_offset_q <= cfg_data;
          REG_NORM_GAIN:   norm_gain_q <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= elev_expected.size();
  end

endmodule

>>> verif/tb.sv
// Top of the testbench for the 2D gradient noise elevation block: clock, reset,
// register phases and item stimulus. Depends on gnd_pkg and gnd_checker.
`timescale 1ns / 100ps

module tb;
  import gnd_pkg::*;

  // Nodes that any query under the register sets below can reach.
  localparam int NODES_USED = 300;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               req_type = 1'b0;
  logic [15:0]        pos_x = '0;
  logic [15:0]        pos_y = '0;
  logic [11:0]        node_index = '0;
  logic signed [15:0] grad_x = '0;
  logic signed [15:0] grad_y = '0;
  logic               done;
  logic [15:0]        elevation;
  logic               in_range;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 errors;
  int                 pending;

  // Map side as the block sees it, tracked for aiming query coordinates.
  int  map_side = 1024;
  bit  no_gaps = 1'b0;

  always #1 clk = ~clk;

  gradient_noise_2d_elevation dut (.*);

  gnd_checker u_checker (.*);

  // Random pause in front of a word, except inside a gap-free stretch.
  task automatic maybe_pause();
    if (!no_gaps && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Presents one word and returns at the edge that accepts it.
  task automatic send_word(logic kind, logic [15:0] x, logic [15:0] y,
                           logic [11:0] idx, logic signed [15:0] gx,
                           logic signed [15:0] gy);
    logic was_busy;
    maybe_pause();
    start <= 1'b1;
    req_type <= kind;
    pos_x <= x;
    pos_y <= y;
    node_index <= idx;
    grad_x <= gx;
    grad_y <= gy;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
  endtask

  function automatic logic signed [15:0] rand_grad();
    case ($urandom_range(0, 9))
      0: return -16'sd16384;
      1: return 16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic write_node(logic [11:0] idx);
    send_word(1'b0, 16'($urandom), 16'($urandom), idx, rand_grad(), rand_grad());
  endtask

  task automatic query(logic [15:0] x, logic [15:0] y);
    send_word(1'b1, x, y, 12'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Coordinate mostly on the map, sometimes at its edge or anywhere at all.
  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (map_side == 0 || r < 8) return 16'($urandom);
    if (r < 13) return 16'(map_side - $urandom_range(0, 1));
    return 16'($urandom_range(0, map_side - 1));
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
    logic was_ready;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      was_ready = cfg_ready;
      @(posedge clk);
    end while (!was_ready);
  endtask

  // Drains all results, then lets the pipeline empty before new registers.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(logic [12:0] side, logic [12:0] stp, logic [15:0] offs,
                          logic [15:0] gain);
    settle();
    write_reg(REG_MAP_SIZE, 16'(side));
    write_reg(REG_GRID_STEP, 16'(stp));
    write_reg(REG_NORM_OFFSET, offs);
    write_reg(REG_NORM_GAIN, gain);
    cfg_valid <= 1'b0;
    map_side = (side > 4096) ? 4096 : side;
  endtask

  // Random mix of queries and table rewrites, with one gap-free stretch.
  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 3) && (i < count / 3 + count / 5);
      if ($urandom_range(0, 99) < 15) write_node(12'($urandom));
      else query(rand_coord(), rand_coord());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every node that a query can reach gets a gradient first.
    for (int n = 0; n < NODES_USED; n++) write_node(12'(n));

    // Directed queries under the reset registers: corners, cell edges, off the map.
    query(16'd0, 16'd0);
    query(16'd1023, 16'd1023);
    query(16'd63, 16'd64);
    query(16'd64, 16'd63);
    query(16'd32, 16'd32);
    query(16'd1024, 16'd0);
    query(16'd0, 16'd1024);
    query(16'hFFFF, 16'hFFFF);
    query(16'd1000, 16'hFFFF);
    write_node(12'd0);
    query(16'd1, 16'd1);
    run_random(300);

    // Largest map and step, extreme offset and gain.
    set_regs(13'd4096, 13'd4096, 16'd32768, 16'hFFFF);
    query(16'd4095, 16'd4095);
    query(16'd0, 16'd0);
    query(16'd4096, 16'd0);
    run_random(150);

    // Map past the cap with unit step: lower nodes fall off the table.
    set_regs(13'h1FFF, 13'd1, 16'd0, 16'd0);
    query(16'd0, 16'd0);
    query(16'd4095, 16'd0);
    query(16'd4096, 16'd1);
    run_random(60);

    // Step that does not divide the map.
    set_regs(13'd100, 13'd7, 16'd20000, 16'd4096);
    run_random(200);

    // Empty map: every query is off the map.
    set_regs(13'd0, 13'd64, 16'd11585, 16'd2896);
    query(16'd0, 16'd0);
    run_random(40);

    // Zero step.
    set_regs(13'd1024, 13'd0, 16'd11585, 16'd2896);
    query(16'd5, 16'd5);
    run_random(40);

    // Wide map with a coarse step that does not divide it.
    set_regs(13'd4095, 13'd300, 16'd0, 16'd8192);
    run_random(250);

    set_regs(13'd3000, 13'd200, 16'd11585, 16'd2896);
    run_random(340);

    settle();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Guard against a hang.
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
